// ===== rtl/sacl_pkg.sv =====
// ----------------------------------------------------------------------------
// sacl_pkg: shared types and constants of the cache tag store
// Field widths, action and register codes, config and result records.
// ----------------------------------------------------------------------------
package sacl_pkg;

  // default geometry
  localparam int SETS_DEF      = 256;
  localparam int WAYS_DEF      = 4;
  localparam int ADDR_BITS_DEF = 32;

  // field widths
  localparam int ACTION_W  = 2;
  localparam int ADDRESS_W = 32;
  localparam int WAY_OUT_W = 2;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 4;
  localparam int CNT_W     = 32;

  // access kinds (code three behaves as a data read)
  localparam logic [ACTION_W-1:0] ACT_READ  = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_WRITE = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_FETCH = 2'd2;
  localparam logic [ACTION_W-1:0] ACT_SPARE = 2'd3;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET_BITS    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INDEX_BITS     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WAYS_IN_USE    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_WRITE_BACK     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_WRITE_ALLOCATE = 3'd4;

  typedef struct packed {
    logic [3:0] offset_bits;
    logic [3:0] index_bits;
    logic [2:0] ways_in_use;
    logic       write_back;
    logic       write_allocate;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    offset_bits:    4'd5,
    index_bits:     4'd8,
    ways_in_use:    3'd4,
    write_back:     1'b1,
    write_allocate: 1'b1
  };

  typedef struct packed {
    logic                 hit;
    logic [WAY_OUT_W-1:0] way;
    logic                 filled;
    logic                 victim_dirty;
    logic [31:0]          victim_tag;
    logic                 write_through;
  } result_t;

endpackage

// ===== rtl/sacl_ram.sv =====
// ----------------------------------------------------------------------------
// sacl_ram: generic simple dual-port RAM
// One write port, one read port with registered data, read-before-write.
// ----------------------------------------------------------------------------
module sacl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                 clk,
  input  logic                                 we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                     wdata,
  input  logic                                 re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                     rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/sacl_update.sv =====
// ----------------------------------------------------------------------------
// sacl_update: lookup and replacement logic for one set
// Tag compare, victim choice, dirty and recency update, result fields.
// ----------------------------------------------------------------------------
module sacl_update #(
  parameter int WAYS  = 4,
  parameter int TAG_W = 32
) (
  input  sacl_pkg::cfg_t                                   cfg,
  input  logic [sacl_pkg::ACTION_W-1:0]                    action,
  input  logic [TAG_W-1:0]                                 tag,
  input  logic [WAYS-1:0][TAG_W-1:0]                       tags_in,
  input  logic [WAYS-1:0]                                  valid_in,
  input  logic [WAYS-1:0]                                  dirty_in,
  input  logic [WAYS-1:0][(WAYS > 1 ? $clog2(WAYS) : 1)-1:0] rank_in,
  output logic [WAYS-1:0][TAG_W-1:0]                       tags_out,
  output logic [WAYS-1:0]                                  valid_out,
  output logic [WAYS-1:0]                                  dirty_out,
  output logic [WAYS-1:0][(WAYS > 1 ? $clog2(WAYS) : 1)-1:0] rank_out,
  output logic                                             miss,
  output sacl_pkg::result_t                                res
);
  import sacl_pkg::*;

  localparam int IDX_W = WAYS > 1 ? $clog2(WAYS) : 1;

  logic [WAYS-1:0]  in_use, match, is_max;
  logic             hit, has_inv, alloc, is_write, mark_dirty, victim_d;
  logic [IDX_W-1:0] hw, iw, lw, vw, tw, r;
  logic [IDX_W+1:0] way_ext;

  always_comb begin
    is_write   = (action == ACT_WRITE);
    mark_dirty = is_write && cfg.write_back;

    for (int w = 0; w < WAYS; w++) begin
      in_use[w] = (w == 0) || (w < int'(cfg.ways_in_use));
      match[w]  = in_use[w] && valid_in[w] && (tags_in[w] == tag);
    end

    // largest rank among ways in use, ranks are distinct
    for (int w = 0; w < WAYS; w++) begin
      is_max[w] = in_use[w];
      for (int k = 0; k < WAYS; k++) begin
        if (k != w && in_use[k] && !(rank_in[k] < rank_in[w])) begin
          is_max[w] = 1'b0;
        end
      end
    end

    // lowest-numbered way wins
    hit = 1'b0;  hw = '0;
    has_inv = 1'b0;  iw = '0;
    lw = '0;
    for (int w = WAYS - 1; w >= 0; w--) begin
      if (match[w]) begin
        hit = 1'b1;
        hw  = IDX_W'(w);
      end
      if (in_use[w] && !valid_in[w]) begin
        has_inv = 1'b1;
        iw      = IDX_W'(w);
      end
      if (is_max[w]) begin
        lw = IDX_W'(w);
      end
    end

    miss     = !hit;
    alloc    = !hit && (!is_write || cfg.write_allocate);
    vw       = has_inv ? iw : lw;
    victim_d = alloc && !has_inv && dirty_in[vw];
    tw       = hit ? hw : vw;
    r        = rank_in[tw];

    tags_out  = tags_in;
    valid_out = valid_in;
    dirty_out = dirty_in;
    rank_out  = rank_in;
    if (hit && mark_dirty) begin
      dirty_out[hw] = 1'b1;
    end
    if (alloc) begin
      tags_out[vw]  = tag;
      valid_out[vw] = 1'b1;
      dirty_out[vw] = mark_dirty;
    end
    if (hit || alloc) begin
      for (int k = 0; k < WAYS; k++) begin
        if (IDX_W'(k) == tw) begin
          rank_out[k] = '0;
        end else if (rank_in[k] < r) begin
          rank_out[k] = rank_in[k] + 1'b1;
        end
      end
    end

    way_ext           = {2'b00, tw};
    res.hit           = hit;
    res.way           = (hit || alloc) ? way_ext[1:0] : '0;
    res.filled        = alloc;
    res.victim_dirty  = victim_d;
    res.victim_tag    = victim_d ? 32'(tags_in[vw]) : 32'd0;
    res.write_through = is_write && !cfg.write_back;
  end

endmodule

// ===== rtl/set_assoc_lru_cache_tags.sv =====
// ----------------------------------------------------------------------------
// set_assoc_lru_cache_tags: tag and policy store of a set-associative cache
// LRU replacement, write-back or write-through, optional write allocate.
// ----------------------------------------------------------------------------
// The sustained rate is one access beat per clock unless the result channel
// stalls; an access passes the lookup stage and then the result register.
// The rate is set by the per-set row of the tag RAM: the row (tags, valid,
// dirty and recency of all ways) is read when the access is taken and
// written back as it leaves the lookup stage, and a bypass register hands
// the row just written to a following access to the same set. After reset
// the block runs a clearing pass over the tag RAM, one set per cycle, and
// takes no access beat until it ends; configuration writes are taken at any
// time and should only be made while the block is idle.
// ----------------------------------------------------------------------------
module set_assoc_lru_cache_tags #(
  parameter int SETS      = sacl_pkg::SETS_DEF,
  parameter int WAYS      = sacl_pkg::WAYS_DEF,
  parameter int ADDR_BITS = sacl_pkg::ADDR_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  // configuration port
  input  logic                           cfg_write,
  input  logic [sacl_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [sacl_pkg::CFG_DAT_W-1:0] cfg_data,
  // access channel
  input  logic                           access_valid,
  output logic                           access_ready,
  input  logic [sacl_pkg::ACTION_W-1:0]  action,
  input  logic [sacl_pkg::ADDRESS_W-1:0] address,
  // result channel
  output logic                           result_valid,
  input  logic                           result_ready,
  output logic                           hit,
  output logic [sacl_pkg::WAY_OUT_W-1:0] way,
  output logic                           filled,
  output logic                           victim_dirty,
  output logic [31:0]                    victim_tag,
  output logic                           write_through
);
  import sacl_pkg::*;

  localparam int SET_W     = SETS > 1 ? $clog2(SETS) : 1;
  localparam int IDX_W     = WAYS > 1 ? $clog2(WAYS) : 1;
  localparam int MASK_BITS = ADDR_BITS < ADDRESS_W ? ADDR_BITS : ADDRESS_W;
  localparam int TAG_W     = MASK_BITS;
  localparam int ROW_W     = WAYS * (TAG_W + 2 + IDX_W);
  // largest k with 2^k <= SETS
  localparam int MAX_IB    = $clog2(SETS + 1) - 1;
  localparam logic [ADDRESS_W-1:0] ADDR_MASK = ADDR_BITS >= ADDRESS_W ?
      {ADDRESS_W{1'b1}} : ADDRESS_W'((64'd1 << MASK_BITS) - 64'd1);

  // configuration
  cfg_t cfg;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= CFG_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_OFFSET_BITS:    cfg.offset_bits    <= cfg_data;
        REG_INDEX_BITS:     cfg.index_bits     <= cfg_data;
        REG_WAYS_IN_USE:    cfg.ways_in_use    <= cfg_data[2:0];
        REG_WRITE_BACK:     cfg.write_back     <= cfg_data[0];
        REG_WRITE_ALLOCATE: cfg.write_allocate <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // clearing pass over the tag RAM after reset
  logic             clr_busy;
  logic [SET_W-1:0] clr_addr;

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_busy <= 1'b1;
      clr_addr <= '0;
    end else if (clr_busy) begin
      clr_addr <= clr_addr + 1'b1;
      if (clr_addr == SET_W'(SETS - 1)) begin
        clr_busy <= 1'b0;
      end
    end
  end

  // address split at acceptance
  logic [ADDRESS_W-1:0] addr_m, set_full, set_mask, tag_full;
  logic [3:0]           ib;
  logic [4:0]           tag_shift;
  logic [SET_W-1:0]     set_in;
  logic [TAG_W-1:0]     tag_in;

  always_comb begin
    addr_m    = address & ADDR_MASK;
    ib        = (cfg.index_bits > 4'(MAX_IB)) ? 4'(MAX_IB) : cfg.index_bits;
    tag_shift = {1'b0, cfg.offset_bits} + {1'b0, ib};
    set_full  = addr_m >> cfg.offset_bits;
    set_mask  = (ADDRESS_W'(1) << ib) - 1'b1;
    set_in    = SET_W'(set_full & set_mask);
    tag_full  = addr_m >> tag_shift;
    tag_in    = TAG_W'(tag_full);
  end

  // lookup stage
  logic                s1_valid, s1_fire, accept, fwd_sel;
  logic [ACTION_W-1:0] s1_action;
  logic [TAG_W-1:0]    s1_tag;
  logic [SET_W-1:0]    s1_set;
  logic [ROW_W-1:0]    ram_rdata, ram_wdata, row_in, row_new, row_clr, fwd_row;
  logic                ram_we;
  logic [SET_W-1:0]    ram_waddr;

  assign s1_fire      = s1_valid && (!result_valid || result_ready);
  assign access_ready = !clr_busy && (!s1_valid || s1_fire);
  assign accept       = access_valid && access_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (s1_fire) begin
      s1_valid <= 1'b0;
    end
  end

  // payload of the lookup stage; the bypass flag marks a row written at
  // the very edge this access read the RAM
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_action <= action;
      s1_tag    <= tag_in;
      s1_set    <= set_in;
      fwd_sel   <= s1_fire && (s1_set == set_in);
    end
    if (s1_fire) begin
      fwd_row <= row_new;
    end
  end

  // reset row: nothing valid or dirty, way w holds rank w
  logic [WAYS-1:0][TAG_W-1:0] clr_tags;
  logic [WAYS-1:0][IDX_W-1:0] clr_rank;

  always_comb begin
    for (int w = 0; w < WAYS; w++) begin
      clr_tags[w] = '0;
      clr_rank[w] = IDX_W'(w);
    end
    row_clr = {clr_tags, {WAYS{1'b0}}, {WAYS{1'b0}}, clr_rank};
  end

  assign ram_we    = clr_busy || s1_fire;
  assign ram_waddr = clr_busy ? clr_addr : s1_set;
  assign ram_wdata = clr_busy ? row_clr : row_new;

  sacl_ram #(
    .WIDTH (ROW_W),
    .DEPTH (SETS)
  ) u_tag_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (accept),
    .raddr (set_in),
    .rdata (ram_rdata)
  );

  assign row_in = fwd_sel ? fwd_row : ram_rdata;

  logic [WAYS-1:0][TAG_W-1:0] tags_in, tags_out;
  logic [WAYS-1:0]            valid_in, valid_out, dirty_in, dirty_out;
  logic [WAYS-1:0][IDX_W-1:0] rank_in, rank_out;
  logic                       miss;
  result_t                    res_next, res;

  assign {tags_in, valid_in, dirty_in, rank_in} = row_in;
  assign row_new = {tags_out, valid_out, dirty_out, rank_out};

  sacl_update #(
    .WAYS  (WAYS),
    .TAG_W (TAG_W)
  ) u_update (
    .cfg       (cfg),
    .action    (s1_action),
    .tag       (s1_tag),
    .tags_in   (tags_in),
    .valid_in  (valid_in),
    .dirty_in  (dirty_in),
    .rank_in   (rank_in),
    .tags_out  (tags_out),
    .valid_out (valid_out),
    .dirty_out (dirty_out),
    .rank_out  (rank_out),
    .miss      (miss),
    .res       (res_next)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (s1_fire) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      res <= res_next;
    end
  end

  assign hit           = res.hit;
  assign way           = res.way;
  assign filled        = res.filled;
  assign victim_dirty  = res.victim_dirty;
  assign victim_tag    = res.victim_tag;
  assign write_through = res.write_through;

  // per-kind access and miss counters, wrapping
  logic [CNT_W-1:0] inst_accesses, inst_misses, data_accesses, data_misses;
  logic             is_inst;

  assign is_inst = (s1_action == ACT_FETCH);

  always_ff @(posedge clk) begin
    if (rst) begin
      inst_accesses <= '0;
      inst_misses   <= '0;
      data_accesses <= '0;
      data_misses   <= '0;
    end else if (s1_fire) begin
      if (is_inst) begin
        inst_accesses <= inst_accesses + 1'b1;
        if (miss) begin
          inst_misses <= inst_misses + 1'b1;
        end
      end else begin
        data_accesses <= data_accesses + 1'b1;
        if (miss) begin
          data_misses <= data_misses + 1'b1;
        end
      end
    end
  end

endmodule

// ===== sim/tb_set_assoc_lru_cache_tags.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_set_assoc_lru_cache_tags: self-checking bench for the cache tag store
// Drives access beats under several geometries and write policies, keeps a
// shadow copy of tags, valid, dirty and recency per set, and checks every
// result beat field by field against the predicted lookup outcome.
// ----------------------------------------------------------------------------
module tb_set_assoc_lru_cache_tags;
  import sacl_pkg::*;

  localparam int SETS   = SETS_DEF;
  localparam int WAYS   = WAYS_DEF;
  localparam int NLINES = SETS * WAYS;
  // widest usable index: largest k with 2^k <= SETS
  localparam int MAX_IB = $clog2(SETS + 1) - 1;

  // dut ports, inputs all known from time zero
  logic                 clk          = 1'b0;
  logic                 rst          = 1'b1;
  logic                 cfg_write    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index    = '0;
  logic [CFG_DAT_W-1:0] cfg_data     = '0;
  logic                 access_valid = 1'b0;
  logic                 access_ready;
  logic [ACTION_W-1:0]  action       = ACT_READ;
  logic [ADDRESS_W-1:0] address      = '0;
  logic                 result_valid;
  logic                 result_ready = 1'b0;
  logic                 hit;
  logic [WAY_OUT_W-1:0] way;
  logic                 filled;
  logic                 victim_dirty;
  logic [31:0]          victim_tag;
  logic                 write_through;

  set_assoc_lru_cache_tags u_dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_write     (cfg_write),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .access_valid  (access_valid),
    .access_ready  (access_ready),
    .action        (action),
    .address       (address),
    .result_valid  (result_valid),
    .result_ready  (result_ready),
    .hit           (hit),
    .way           (way),
    .filled        (filled),
    .victim_dirty  (victim_dirty),
    .victim_tag    (victim_tag),
    .write_through (write_through)
  );

  // 10 ns clock
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // --------------------------------------------------------------------------
  // shadow state of the tag store
  // --------------------------------------------------------------------------
  logic [31:0] shadow_tag   [NLINES];
  logic        shadow_valid [NLINES];
  logic        shadow_dirty [NLINES];
  logic [1:0]  shadow_rank  [NLINES];   // 0 is most recent
  logic [31:0] inst_access_cnt, inst_miss_cnt, data_access_cnt, data_miss_cnt;
  cfg_t        cur_cfg;

  result_t     pending_results[$];      // predicted result beats, oldest first
  int          mismatch_count = 0;

  // knobs for idling on both channels
  bit          tx_gaps_on  = 1'b1;
  bit          rx_stall_on = 1'b1;
  int          rx_hold     = 0;
  logic [31:0] hot_tag_base;

  function automatic void reset_shadow();
    int i;
    for (i = 0; i < NLINES; i++) begin
      shadow_tag[i]   = '0;
      shadow_valid[i] = 1'b0;
      shadow_dirty[i] = 1'b0;
      shadow_rank[i]  = 2'(i % WAYS);
    end
    inst_access_cnt = '0;
    inst_miss_cnt   = '0;
    data_access_cnt = '0;
    data_miss_cnt   = '0;
    cur_cfg         = CFG_RESET;
  endfunction

  function automatic int eff_index_bits();
    return (int'(cur_cfg.index_bits) < MAX_IB) ? int'(cur_cfg.index_bits) : MAX_IB;
  endfunction

  // ways in use: zero acts as one, above WAYS acts as WAYS
  function automatic int eff_ways();
    if (cur_cfg.ways_in_use == 0) return 1;
    if (int'(cur_cfg.ways_in_use) > WAYS) return WAYS;
    return int'(cur_cfg.ways_in_use);
  endfunction

  // move one way to most recent, ages the younger ones
  function automatic void promote_way(int base, int w);
    logic [1:0] r;
    int k;
    r = shadow_rank[base + w];
    for (k = 0; k < WAYS; k++)
      if (shadow_rank[base + k] < r) shadow_rank[base + k]++;
    shadow_rank[base + w] = '0;
  endfunction

  // lookup outcome for one accepted access, updates the shadow state
  function automatic result_t predict_lookup(logic [ACTION_W-1:0] act,
                                             logic [ADDRESS_W-1:0] addr);
    result_t     res;
    int          ob, ib, nw, set_idx, base, w, hw, vw;
    logic [1:0]  vr;
    logic [31:0] tag;
    bit          is_write, is_inst, found_hit, found_free;
    res        = '0;
    ob         = int'(cur_cfg.offset_bits);
    ib         = eff_index_bits();
    nw         = eff_ways();
    is_write   = (act == ACT_WRITE);
    is_inst    = (act == ACT_FETCH);   // code three falls through as a data read
    set_idx    = int'((addr >> ob) & ((32'd1 << ib) - 32'd1));
    tag        = addr >> (ob + ib);
    base       = set_idx * WAYS;
    found_hit  = 1'b0;
    found_free = 1'b0;
    hw         = 0;
    vw         = 0;
    vr         = '0;

    for (w = 0; w < nw; w++)
      if (!found_hit && shadow_valid[base + w] && shadow_tag[base + w] == tag) begin
        found_hit = 1'b1;
        hw        = w;
      end

    if (is_inst) inst_access_cnt++;
    else data_access_cnt++;

    if (found_hit) begin
      if (is_write && cur_cfg.write_back) shadow_dirty[base + hw] = 1'b1;
      promote_way(base, hw);
      res.hit = 1'b1;
      res.way = WAY_OUT_W'(hw);
    end else begin
      if (is_inst) inst_miss_cnt++;
      else data_miss_cnt++;
      if (!is_write || cur_cfg.write_allocate) begin
        // lowest invalid way first, else the oldest way in use
        for (w = 0; w < nw; w++)
          if (!found_free && !shadow_valid[base + w]) begin
            found_free = 1'b1;
            vw         = w;
          end
        if (!found_free) begin
          for (w = 0; w < nw; w++)
            if (w == 0 || shadow_rank[base + w] > vr) begin
              vr = shadow_rank[base + w];
              vw = w;
            end
          if (shadow_dirty[base + vw]) begin
            res.victim_dirty = 1'b1;
            res.victim_tag   = shadow_tag[base + vw];
          end
        end
        shadow_tag[base + vw]   = tag;
        shadow_valid[base + vw] = 1'b1;
        // a write-allocate fill under write-back holds the written data
        shadow_dirty[base + vw] = is_write && cur_cfg.write_back;
        promote_way(base, vw);
        res.filled = 1'b1;
        res.way    = WAY_OUT_W'(vw);
      end
    end
    res.write_through = is_write && !cur_cfg.write_back;
    return res;
  endfunction

  // --------------------------------------------------------------------------
  // result checking
  // --------------------------------------------------------------------------
  task automatic compare_field(string name, logic [31:0] exp_val, logic [31:0] act_val);
    if (exp_val !== act_val) begin
      mismatch_count++;
      $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, exp_val, act_val);
    end
  endtask

  // every accepted result beat is matched against the oldest prediction
  always @(posedge clk) begin
    result_t exp_res;
    if (!rst && result_valid && result_ready) begin
      if (pending_results.size() == 0) begin
        mismatch_count++;
        $display("%0t: result beat with nothing predicted, expected none actual hit=%0b way=%0d",
                 $time, hit, way);
      end else begin
        exp_res = pending_results.pop_front();
        compare_field("hit",           exp_res.hit,           hit);
        compare_field("way",           exp_res.way,           way);
        compare_field("filled",        exp_res.filled,        filled);
        compare_field("victim_dirty",  exp_res.victim_dirty,  victim_dirty);
        compare_field("victim_tag",    exp_res.victim_tag,    victim_tag);
        compare_field("write_through", exp_res.write_through, write_through);
      end
    end
  end

  // receiver: ready or stalled in runs of random length
  always @(posedge clk) begin
    if (rx_hold != 0) begin
      rx_hold <= rx_hold - 1;
    end else begin
      rx_hold      <= $urandom_range(0, 7);
      result_ready <= !rx_stall_on || ($urandom_range(0, 2) != 0);
    end
  end

  // --------------------------------------------------------------------------
  // stimulus helpers
  // --------------------------------------------------------------------------
  // one access beat; returns at the edge where it was taken
  task automatic send_access(logic [ACTION_W-1:0] act, logic [ADDRESS_W-1:0] addr);
    access_valid <= 1'b1;
    action       <= act;
    address      <= addr;
    do @(posedge clk); while (!access_ready);
    pending_results.push_back(predict_lookup(act, addr));
  endtask

  task automatic idle_gap(int cycles);
    if (cycles > 0) begin
      access_valid <= 1'b0;
      repeat (cycles) @(posedge clk);
    end
  endtask

  // sender holds off until every predicted result beat has come back
  task automatic wait_idle();
    access_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  function automatic cfg_t mk_cfg(int ob, int ib, int nw, bit wb, bit wa);
    cfg_t c;
    c.offset_bits    = 4'(ob);
    c.index_bits     = 4'(ib);
    c.ways_in_use    = 3'(nw);
    c.write_back     = wb;
    c.write_allocate = wa;
    return c;
  endfunction

  // all five registers, only once the block has gone idle
  task automatic apply_cfg(cfg_t c);
    wait_idle();
    cfg_write <= 1'b1;
    cfg_index <= REG_OFFSET_BITS;
    cfg_data  <= c.offset_bits;
    @(posedge clk);
    cfg_index <= REG_INDEX_BITS;
    cfg_data  <= c.index_bits;
    @(posedge clk);
    cfg_index <= REG_WAYS_IN_USE;
    cfg_data  <= {1'b0, c.ways_in_use};
    @(posedge clk);
    cfg_index <= REG_WRITE_BACK;
    cfg_data  <= {3'b000, c.write_back};
    @(posedge clk);
    cfg_index <= REG_WRITE_ALLOCATE;
    cfg_data  <= {3'b000, c.write_allocate};
    @(posedge clk);
    cfg_write <= 1'b0;
    cur_cfg   = c;
    @(posedge clk);
  endtask

  // build an address from tag, set and offset under the current geometry
  function automatic logic [31:0] compose_address(logic [31:0] tag, int set_idx,
                                                  logic [31:0] offs);
    int ob, ib;
    ob = int'(cur_cfg.offset_bits);
    ib = eff_index_bits();
    return (tag << (ob + ib)) |
           ((32'(set_idx) & ((32'd1 << ib) - 32'd1)) << ob) |
           (offs & ((32'd1 << ob) - 32'd1));
  endfunction

  // mostly a small hot working set so lines hit and get evicted, some noise
  function automatic logic [31:0] pick_address();
    if ($urandom_range(0, 99) < 15) return $urandom();
    return compose_address(hot_tag_base + 32'($urandom_range(0, 6)),
                           $urandom_range(0, 3), $urandom());
  endfunction

  // random traffic in bursts, with one full drain half way through
  task automatic run_traffic(int n_items);
    int i, b, burst;
    hot_tag_base = ($urandom_range(0, 1) != 0) ? $urandom() : 32'd0;
    i = 0;
    while (i < n_items) begin
      burst = $urandom_range(1, 16);
      for (b = 0; b < burst && i < n_items; b++) begin
        send_access(ACTION_W'($urandom_range(0, 3)), pick_address());
        i++;
        if (i == n_items / 2) wait_idle();
      end
      if (tx_gaps_on) idle_gap($urandom_range(0, 5));
    end
  endtask

  // --------------------------------------------------------------------------
  // tests
  // --------------------------------------------------------------------------
  // hit, dirty write hit, fills into free ways, dirty lru eviction
  task automatic test_basic_policy();
    apply_cfg(CFG_RESET);
    send_access(ACT_READ,  compose_address(32'd7, 1, 32'd0));
    send_access(ACT_READ,  compose_address(32'd7, 1, 32'hFFFF_FFFF));
    send_access(ACT_WRITE, compose_address(32'd7, 1, 32'd4));
    send_access(ACT_FETCH, compose_address(32'd8, 1, 32'd0));
    send_access(ACT_FETCH, compose_address(32'd9, 1, 32'd0));
    send_access(ACT_FETCH, compose_address(32'd10, 1, 32'd0));
    // action three looks up like a data read
    send_access(ACT_SPARE, compose_address(32'd8, 1, 32'd0));
    // set full: oldest way is the dirty one
    send_access(ACT_READ,  compose_address(32'd11, 1, 32'd0));
    // write-allocate fill under write-back comes in dirty
    send_access(ACT_WRITE, compose_address(32'd12, 1, 32'd0));
    send_access(ACT_READ,  32'hFFFF_FFFF);
    send_access(ACT_WRITE, 32'hFFFF_FFFF);
    send_access(ACT_FETCH, 32'h0000_0000);
  endtask

  // write miss with no allocate, write hits reported to memory
  task automatic test_write_through_no_allocate();
    apply_cfg(mk_cfg(5, 8, 4, 1'b0, 1'b0));
    send_access(ACT_WRITE, compose_address(32'd20, 2, 32'd0));
    send_access(ACT_READ,  compose_address(32'd20, 2, 32'd0));
    send_access(ACT_WRITE, compose_address(32'd20, 2, 32'd3));
    send_access(ACT_WRITE, 32'hFFFF_FFFF);
  endtask

  // extreme geometry: zero offset, one set, clamped index and ways
  task automatic test_geometry_extremes();
    apply_cfg(mk_cfg(0, 0, 1, 1'b1, 1'b1));
    send_access(ACT_WRITE, 32'h0000_0001);
    send_access(ACT_READ,  32'h8000_0000);
    send_access(ACT_READ,  32'h0000_0001);
    apply_cfg(mk_cfg(15, 15, 7, 1'b1, 1'b0));
    send_access(ACT_READ,  32'hFFFF_FFFF);
    send_access(ACT_WRITE, 32'hFFFF_FFFF);
    send_access(ACT_WRITE, 32'h0000_7FFF);
    apply_cfg(mk_cfg(12, 1, 0, 1'b0, 1'b1));
    send_access(ACT_FETCH, 32'h0000_1000);
    send_access(ACT_WRITE, 32'h0000_3000);
    send_access(ACT_READ,  32'h0000_1FFF);
  endtask

  task automatic test_hot_sets_default();
    apply_cfg(CFG_RESET);
    tx_gaps_on  = 1'b1;
    rx_stall_on = 1'b1;
    run_traffic(400);
  endtask

  // one set, four ways: constant eviction pressure
  task automatic test_single_set_thrash();
    apply_cfg(mk_cfg(2, 0, 4, 1'b1, 1'b1));
    tx_gaps_on  = 1'b0;
    rx_stall_on = 1'b0;
    run_traffic(200);
  endtask

  task automatic test_write_through_traffic();
    apply_cfg(mk_cfg(12, 8, 2, 1'b0, 1'b0));
    tx_gaps_on  = 1'b1;
    rx_stall_on = 1'b0;
    run_traffic(200);
  endtask

  task automatic test_no_allocate_write_back();
    apply_cfg(mk_cfg(4, 3, 3, 1'b1, 1'b0));
    tx_gaps_on  = 1'b0;
    rx_stall_on = 1'b1;
    run_traffic(200);
  endtask

  // any register value the fields allow, stored lines kept across changes
  task automatic test_random_geometry();
    int p;
    tx_gaps_on  = 1'b1;
    rx_stall_on = 1'b1;
    for (p = 0; p < 3; p++) begin
      apply_cfg(mk_cfg($urandom_range(0, 15), $urandom_range(0, 15), $urandom_range(0, 7),
                       1'($urandom_range(0, 1)), 1'($urandom_range(0, 1))));
      run_traffic(150);
    end
  endtask

  // --------------------------------------------------------------------------
  // sequence
  // --------------------------------------------------------------------------
  initial begin
    reset_shadow();
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_basic_policy();
    test_write_through_no_allocate();
    test_geometry_extremes();
    test_hot_sets_default();
    test_single_set_thrash();
    test_write_through_traffic();
    test_no_allocate_write_back();
    test_random_geometry();

    wait_idle();
    repeat (5) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // hang guard, far beyond the slowest legal run
  initial begin
    #3_000_000;
    $display("Regression FAIL");
    $finish;
  end

endmodule
